@@ rtl/core/z2_boundary_column_reducer_unit_assert.svh @@
// assertion macros for the z2 boundary column reducer
// no dependencies; included by modules that check their own logic
`ifndef Z2_BOUNDARY_COLUMN_REDUCER_UNIT_ASSERT_SVH
`define Z2_BOUNDARY_COLUMN_REDUCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define Z2BCR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define Z2BCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define Z2BCR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define Z2BCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/z2bcr_pkg.sv @@
// shared types and constants for the z2 boundary column reducer
// no dependencies
package z2bcr_pkg;

   localparam int MaxSimplices  = 256;
   localparam int RowWidth      = $clog2(MaxSimplices);
   localparam int GroupWidth    = 16;
   localparam int GroupCount    = MaxSimplices / GroupWidth;
   localparam int GroupIdxWidth = $clog2(GroupCount);
   localparam int LowWidth      = $clog2(GroupWidth);
   localparam int DimWidth      = 4;
   localparam int CountWidth    = 8;

   typedef logic [MaxSimplices-1:0] column_type;
   typedef logic [RowWidth-1:0]     row_type;

   typedef struct packed {
      logic [7:0]          row_index;
      logic                entry_valid;
      logic                last_of_column;
      logic [DimWidth-1:0] simplex_dim;
   } req_type;

   typedef struct packed {
      logic [CountWidth-1:0] column_index;
      logic [7:0]            birth_index;
      logic                  essential;
      logic [DimWidth-1:0]   pair_dim;
   } rsp_type;

   // result of the leading-one search
   typedef struct packed {
      logic    empty;
      row_type pivot;
   } lead_type;

   // access to the reduced column store
   typedef struct packed {
      logic    wr_en;
      logic    rd_en;
      row_type addr;
   } store_req_type;

endpackage

@@ rtl/core/z2bcr_store.sv @@
// reduced column store: one column per pivot row, registered read
// depends on z2bcr_pkg
module z2bcr_store (
   input  logic                      clock,
   input  z2bcr_pkg::store_req_type  req,
   input  z2bcr_pkg::column_type     wr_data,
   output z2bcr_pkg::column_type     rd_data
);

   z2bcr_pkg::column_type mem [z2bcr_pkg::MaxSimplices];
   z2bcr_pkg::column_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/z2bcr_lead.sv @@
// two-step leading-one search over the work column
// group step is registered, row step within the group follows; depends on z2bcr_pkg
module z2bcr_lead (
   input  logic                   clock,
   input  z2bcr_pkg::column_type  work,
   output z2bcr_pkg::lead_type    lead
);

   logic [z2bcr_pkg::GroupCount-1:0]    grp_nz;
   logic [z2bcr_pkg::GroupIdxWidth-1:0] grp_in;
   logic [z2bcr_pkg::GroupIdxWidth-1:0] grp_ff;
   logic                                any_in;
   logic                                any_ff;
   logic [z2bcr_pkg::GroupWidth-1:0]    sel;
   logic [z2bcr_pkg::LowWidth-1:0]      low;

   // highest nonzero group
   always_comb begin
      grp_in = '0;
      any_in = 1'b0;
      for (int g = 0; g < z2bcr_pkg::GroupCount; g++) begin
         grp_nz[g] = |work[g*z2bcr_pkg::GroupWidth +: z2bcr_pkg::GroupWidth];
         if (grp_nz[g]) begin
            grp_in = z2bcr_pkg::GroupIdxWidth'(g);
            any_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      any_ff <= any_in;
   end

   // highest set row inside the chosen group
   always_comb begin
      sel = work[{grp_ff, {z2bcr_pkg::LowWidth{1'b0}}} +: z2bcr_pkg::GroupWidth];
      low = '0;
      for (int b = 0; b < z2bcr_pkg::GroupWidth; b++) begin
         if (sel[b]) begin
            low = z2bcr_pkg::LowWidth'(b);
         end
      end
   end

   assign lead.empty = !any_ff;
   assign lead.pivot = {grp_ff, low};

endmodule

@@ rtl/core/z2_boundary_column_reducer_unit.sv @@
// top level of the z2 boundary column reducer: sequencer, work column, pivot flags
// depends on z2bcr_pkg, z2bcr_store, z2bcr_lead and the assertion header
//
//   channel  ports                      direction  beat taken when
//   req      start, busy, req_data      in         start && !busy
//   rsp      rsp_strobe, rsp_data       out        rsp_strobe (one cycle, no stall)
//
// a column end runs the search (group step, then row step) and then, for each stored
//   column xor'ed in, a store read and a merge before the search runs again
// the single-port column store has a registered read, as does the group step of the search
// reset clears the work column, the pivot flags and the column counter at once;
//   the store itself holds no reset state and is read only under a set pivot flag
// busy stays high from the last beat of a column until its result strobe
`include "z2_boundary_column_reducer_unit_assert.svh"

module z2_boundary_column_reducer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  z2bcr_pkg::req_type req_data,
   output logic               rsp_strobe,
   output z2bcr_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_LOAD,    // taking entry beats
      ST_SCAN,    // group step of the search
      ST_DECIDE,  // pivot known: emit, store, or fetch
      ST_MERGE    // xor fetched column into the work column
   } state_type;

   state_type                        state_ff, state_in;
   z2bcr_pkg::column_type            work_ff, work_in;
   logic [z2bcr_pkg::MaxSimplices-1:0] taken_ff, taken_in;
   logic [z2bcr_pkg::CountWidth-1:0] count_ff, count_in;
   logic [z2bcr_pkg::DimWidth-1:0]   dim_ff, dim_in;
   logic                             strobe_ff, strobe_in;
   z2bcr_pkg::rsp_type               rsp_ff, rsp_in;

   z2bcr_pkg::lead_type      lead;
   z2bcr_pkg::store_req_type st_req;
   z2bcr_pkg::column_type    st_rd_data;
   logic                     accept;

   assign busy   = (state_ff != ST_LOAD);
   assign accept = start && !busy;

   z2bcr_lead u_lead (
      .clock (clock),
      .work  (work_ff),
      .lead  (lead)
   );

   z2bcr_store u_store (
      .clock   (clock),
      .req     (st_req),
      .wr_data (work_ff),
      .rd_data (st_rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      work_in   = work_ff;
      taken_in  = taken_ff;
      count_in  = count_ff;
      dim_in    = dim_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      st_req.wr_en = 1'b0;
      st_req.rd_en = 1'b0;
      st_req.addr  = lead.pivot;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (req_data.entry_valid) begin
                  work_in[req_data.row_index] = 1'b1;
               end
               if (req_data.last_of_column) begin
                  dim_in   = req_data.simplex_dim;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!lead.empty && taken_ff[lead.pivot]) begin
               // another column owns this pivot: fetch it
               st_req.rd_en = 1'b1;
               state_in     = ST_MERGE;
            end else begin
               // column done: finite pair if anything is left, else essential
               rsp_in.column_index = count_ff;
               rsp_in.pair_dim     = dim_ff;
               rsp_in.essential    = lead.empty;
               rsp_in.birth_index  = lead.empty ? count_ff : lead.pivot;
               if (!lead.empty) begin
                  st_req.wr_en          = 1'b1;
                  taken_in[lead.pivot]  = 1'b1;
               end
               strobe_in = 1'b1;
               count_in  = count_ff + z2bcr_pkg::CountWidth'(1);
               work_in   = '0;
               state_in  = ST_LOAD;
            end
         end
         ST_MERGE: begin
            work_in  = work_ff ^ st_rd_data;
            state_in = ST_SCAN;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         work_ff   <= '0;
         taken_ff  <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         work_ff   <= work_in;
         taken_ff  <= taken_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      dim_ff <= dim_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // a result strobe is never held
   `Z2BCR_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe,
      "result strobe held")
   // a pivot is claimed only once
   `Z2BCR_ASSERT_NOW(a_store_fresh, clock, reset, st_req.wr_en, !taken_ff[st_req.addr],
      "store write to a taken pivot")
   // only columns that were stored are fetched
   `Z2BCR_ASSERT_NOW(a_fetch_taken, clock, reset, st_req.rd_en, taken_ff[st_req.addr],
      "store read of an unwritten column")
   // the work column is empty when a result goes out
   `Z2BCR_ASSERT_NOW(a_work_cleared, clock, reset, rsp_strobe, work_ff == '0,
      "work column not cleared after result")
   // a fetch is always followed by a merge cycle
   `Z2BCR_ASSERT_NEXT(a_fetch_merge, clock, reset, st_req.rd_en, state_ff == ST_MERGE,
      "fetch without merge")

endmodule
